// File: rtl/tlp_pkg.sv
// Shared constants, types and helpers for the timestamp line parser.
`timescale 1ns / 1ps
package tlp_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int PW = $clog2(LINE_DEPTH + 1);

	localparam int MIN_TEXT_LEN = 17;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(16);

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// colon positions, each closing one field
	localparam logic [CNT_W-1:0] POS_DAY_END = CNT_W'(2);
	localparam logic [CNT_W-1:0] POS_MONTH_END = CNT_W'(5);
	localparam logic [CNT_W-1:0] POS_YEAR_END = CNT_W'(10);
	localparam logic [CNT_W-1:0] POS_HOUR_END = CNT_W'(13);
	localparam logic [CNT_W-1:0] POS_MINUTE_END = CNT_W'(16);

	localparam int ACC_W = 14;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} scan_state_t;

	typedef struct packed {
		logic go;
		logic short_line;
	} scan_req_t;

	function automatic logic is_colon_pos(input logic [CNT_W-1:0] pos);
		return (pos == POS_DAY_END) || (pos == POS_MONTH_END) || (pos == POS_YEAR_END) ||
			(pos == POS_HOUR_END) || (pos == POS_MINUTE_END);
	endfunction

endpackage

// File: rtl/timestamp_line_parser.sv
// Top level of the timestamp line parser: line store writes and scan control.
//
//  channel   signals                        handshake
//  request   start, rx_byte                 taken when start & !busy
//  result    strobe, valid_res, day, month, one cycle pulse on strobe, no stall
//            year, hour, minute
//
// A data byte is written to the line store at acceptance while the store has room.
// A terminator of a line of at least 17 text bytes holds busy through the scan state,
// which reads positions 0 to 16 on the single read port, the drain state and the result state.
// A shorter line holds busy only in the result state.
// The result receiver cannot stall; strobe is high for exactly one cycle.
// Reset clears position, length and scan state; store contents are not cleared.
`timescale 1ns / 1ps
module timestamp_line_parser import tlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  rx_byte,
	output logic        strobe,
	output logic        valid_res,
	output logic [6:0]  day,
	output logic [6:0]  month,
	output logic [13:0] year,
	output logic [6:0]  hour,
	output logic [6:0]  minute
);

	logic [PW-1:0] wpos_q;
	logic [PW-1:0] len_q;
	logic zero_q;
	logic accept;
	logic term;
	logic wr_en;
	logic [AW-1:0] rd_addr;
	logic [7:0] rd_data;
	scan_req_t req;

	assign accept = start && !busy;
	assign term = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign wr_en = accept && !term && (wpos_q < PW'(LINE_DEPTH));

	assign req.go = accept && term;
	assign req.short_line = (len_q < PW'(MIN_TEXT_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			len_q <= '0;
			zero_q <= 1'b0;
		end else if (req.go) begin
			wpos_q <= '0;
			len_q <= '0;
			zero_q <= 1'b0;
		end else if (wr_en) begin
			wpos_q <= wpos_q + PW'(1);
			if (rx_byte == 8'h00) begin
				zero_q <= 1'b1;
			end else if (!zero_q) begin
				len_q <= len_q + PW'(1);
			end
		end
	end

	tlp_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wpos_q[AW-1:0]),
		.wdata(rx_byte),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	tlp_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.busy     (busy),
		.strobe   (strobe),
		.valid_res(valid_res),
		.day      (day),
		.month    (month),
		.year     (year),
		.hour     (hour),
		.minute   (minute)
	);

endmodule

// File: rtl/tlp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/tlp_scan.sv
// Line scan sequencer: reads positions 0..16, checks format, decodes fields.
`timescale 1ns / 1ps
module tlp_scan import tlp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  scan_req_t     req,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          busy,
	output logic          strobe,
	output logic          valid_res,
	output logic [6:0]    day,
	output logic [6:0]    month,
	output logic [13:0]   year,
	output logic [6:0]    hour,
	output logic [6:0]    minute
);

	scan_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pos_s1;
	logic vld_s1;
	logic ok_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_next;
	logic [6:0] day_q, month_q, hour_q, minute_q;
	logic [13:0] year_q;
	logic digit_ok;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.go) begin
					state_d = req.short_line ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_POS) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		strobe = (state_q == ST_EMIT);
		rd_addr = AW'(cnt_q);
	end

	assign digit_ok = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
	assign acc_next = ACC_W'({acc_q, 3'b000}) + ACC_W'({acc_q, 1'b0}) +
		ACC_W'(rd_data[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_IDLE && req.go) begin
				ok_q <= !req.short_line;
			end else if (vld_s1) begin
				if (is_colon_pos(pos_s1)) begin
					if (rd_data != CH_COLON) begin
						ok_q <= 1'b0;
					end
				end else if (!digit_ok) begin
					ok_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= cnt_q;
		if (state_q == ST_IDLE) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			if (is_colon_pos(pos_s1)) begin
				acc_q <= '0;
				case (pos_s1)
					POS_DAY_END: day_q <= acc_q[6:0];
					POS_MONTH_END: month_q <= acc_q[6:0];
					POS_YEAR_END: year_q <= acc_q[13:0];
					POS_HOUR_END: hour_q <= acc_q[6:0];
					POS_MINUTE_END: minute_q <= acc_q[6:0];
					default: ;
				endcase
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	assign valid_res = ok_q;
	assign day = ok_q ? day_q : '0;
	assign month = ok_q ? month_q : '0;
	assign year = ok_q ? year_q : '0;
	assign hour = ok_q ? hour_q : '0;
	assign minute = ok_q ? minute_q : '0;

endmodule

// File: rtl/tlp_chk.sv
// Port-level assertions for the timestamp line parser, bound to the top level.
`timescale 1ns / 1ps
module tlp_chk import tlp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [7:0]  rx_byte,
	input logic        strobe,
	input logic        valid_res,
	input logic [6:0]  day,
	input logic [6:0]  month,
	input logic [13:0] year,
	input logic [6:0]  hour,
	input logic [6:0]  minute
);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result strobe without busy");

	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe longer than one cycle");

	a_term_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (rx_byte == CH_CR || rx_byte == CH_LF)) |=> busy)
		else $error("terminator request did not start a scan");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !valid_res) |-> (day == '0 && month == '0 && year == '0 &&
			hour == '0 && minute == '0))
		else $error("invalid result with nonzero fields");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && valid_res) |-> (day <= 7'd99 && month <= 7'd99 && year <= 14'd9999 &&
			hour <= 7'd99 && minute <= 7'd99))
		else $error("valid result field out of decimal range");

endmodule

bind timestamp_line_parser tlp_chk u_tlp_chk (.*);

// File: dv/tb_timestamp_line_parser.sv
// Self-checking testbench for the timestamp line parser: byte requests in, one parse per line out.
`timescale 1ns / 1ps
module tb_timestamp_line_parser;
	import tlp_pkg::*;

	typedef struct packed {
		logic        valid;
		logic [6:0]  day;
		logic [6:0]  month;
		logic [13:0] year;
		logic [6:0]  hour;
		logic [6:0]  minute;
	} stamp_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		stamp_t     want;
	} dir_row_t;

	localparam stamp_t NO_STAMP = '0;
	localparam stamp_t MIXED_STAMP = '{1'b1, 7'd9, 7'd90, 14'd9009, 7'd0, 7'd99};
	localparam int COLON_POS [5] = '{2, 5, 10, 13, 16};
	localparam int DIGIT_POS [12] = '{0, 1, 3, 4, 6, 7, 8, 9, 11, 12, 14, 15};
	localparam int RANDOM_BYTES = 1050;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  rx_byte;
	logic        strobe;
	logic        valid_res;
	logic [6:0]  day;
	logic [6:0]  month;
	logic [13:0] year;
	logic [6:0]  hour;
	logic [6:0]  minute;

	// predictor state
	logic [7:0]  line_buf [LINE_DEPTH];
	int unsigned wr_pos;
	int unsigned txt_len;
	bit          zero_hit;

	stamp_t      stamp_q [$];
	stamp_t      want;
	int          err_cnt;
	int          sent_cnt;
	int          line_cnt;
	int          good_cnt;
	int          bad_cnt;
	int          idle_pct;

	// empty line, extreme bytes in a short line, valid line with a zero byte after it
	dir_row_t dir_tab [24] = '{
		'{CH_CR, 1'b1, NO_STAMP},
		'{8'hFF, 1'b0, NO_STAMP}, '{8'h00, 1'b0, NO_STAMP}, '{CH_LF, 1'b1, NO_STAMP},
		'{"0", 1'b0, NO_STAMP}, '{"9", 1'b0, NO_STAMP}, '{":", 1'b0, NO_STAMP},
		'{"9", 1'b0, NO_STAMP}, '{"0", 1'b0, NO_STAMP}, '{":", 1'b0, NO_STAMP},
		'{"9", 1'b0, NO_STAMP}, '{"0", 1'b0, NO_STAMP}, '{"0", 1'b0, NO_STAMP},
		'{"9", 1'b0, NO_STAMP}, '{":", 1'b0, NO_STAMP},
		'{"0", 1'b0, NO_STAMP}, '{"0", 1'b0, NO_STAMP}, '{":", 1'b0, NO_STAMP},
		'{"9", 1'b0, NO_STAMP}, '{"9", 1'b0, NO_STAMP}, '{":", 1'b0, NO_STAMP},
		'{8'h00, 1'b0, NO_STAMP}, '{8'hFF, 1'b0, NO_STAMP}, '{CH_CR, 1'b1, MIXED_STAMP}
	};

	timestamp_line_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.rx_byte  (rx_byte),
		.strobe   (strobe),
		.valid_res(valid_res),
		.day      (day),
		.month    (month),
		.year     (year),
		.hour     (hour),
		.minute   (minute)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] ERROR: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic int unsigned digit_at(input int pos);
		return int'(line_buf[pos] - CH_ZERO);
	endfunction

	// advance the line state by one byte; returns 1 when the byte ends a line
	function automatic bit parse_byte(input logic [7:0] ch, output stamp_t res);
		bit ok;
		res = NO_STAMP;
		if (ch == CH_CR || ch == CH_LF) begin
			ok = (txt_len >= MIN_TEXT_LEN);
			for (int i = 0; i < 5 && ok; i++)
				if (line_buf[COLON_POS[i]] != CH_COLON)
					ok = 1'b0;
			for (int i = 0; i < 12 && ok; i++)
				if (line_buf[DIGIT_POS[i]] < CH_ZERO || line_buf[DIGIT_POS[i]] > CH_NINE)
					ok = 1'b0;
			if (ok) begin
				res.valid = 1'b1;
				res.day = 7'(digit_at(0) * 10 + digit_at(1));
				res.month = 7'(digit_at(3) * 10 + digit_at(4));
				res.year = 14'(digit_at(6) * 1000 + digit_at(7) * 100 +
					digit_at(8) * 10 + digit_at(9));
				res.hour = 7'(digit_at(11) * 10 + digit_at(12));
				res.minute = 7'(digit_at(14) * 10 + digit_at(15));
			end
			wr_pos = 0;
			txt_len = 0;
			zero_hit = 1'b0;
			return 1'b1;
		end
		if (wr_pos < LINE_DEPTH) begin
			line_buf[wr_pos] = ch;
			wr_pos++;
			if (ch == 8'h00)
				zero_hit = 1'b1;
			else if (!zero_hit)
				txt_len++;
		end
		return 1'b0;
	endfunction

	// start stays high across back-to-back requests; called at a rising edge
	task automatic push_byte(input logic [7:0] b, input bit typed, input stamp_t typed_want);
		stamp_t got;
		start <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (busy);
		if (parse_byte(b, got)) begin
			stamp_q.push_back(typed ? typed_want : got);
			line_cnt++;
		end
		sent_cnt++;
	endtask

	task automatic sender_gap();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(3) == 0 ? $urandom_range(5, 24) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (stamp_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] near_miss();
		case ($urandom_range(5))
			0: return 8'h2F;
			1: return 8'h3A;
			2: return 8'h30;
			3: return 8'h39;
			4: return 8'h00;
			default: return text_byte();
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (stamp_q.size() == 0) begin
				report_mismatch("result with no line pending");
			end else begin
				want = stamp_q.pop_front();
				if (valid_res !== want.valid)
					report_mismatch($sformatf("valid_res %b, want %b", valid_res, want.valid));
				if (day !== want.day)
					report_mismatch($sformatf("day %0d, want %0d", day, want.day));
				if (month !== want.month)
					report_mismatch($sformatf("month %0d, want %0d", month, want.month));
				if (year !== want.year)
					report_mismatch($sformatf("year %0d, want %0d", year, want.year));
				if (hour !== want.hour)
					report_mismatch($sformatf("hour %0d, want %0d", hour, want.hour));
				if (minute !== want.minute)
					report_mismatch($sformatf("minute %0d, want %0d", minute, want.minute));
				if (want.valid)
					good_cnt++;
				else
					bad_cnt++;
			end
		end
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d lines outstanding", stamp_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [7:0] line_q [$];
		int kind;
		int pos;
		arst_n = 1'b0;
		start = 1'b0;
		rx_byte = 8'h00;
		wr_pos = 0;
		txt_len = 0;
		zero_hit = 1'b0;
		err_cnt = 0;
		sent_cnt = 0;
		line_cnt = 0;
		good_cnt = 0;
		bad_cnt = 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			push_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
			sender_gap();
		end
		drain_results();

		while (sent_cnt < RANDOM_BYTES) begin
			case ((line_cnt / 12) % 4)
				1: idle_pct = 71;
				3: idle_pct = 23;
				default: idle_pct = 0;
			endcase
			line_q.delete();
			kind = $urandom_range(99);
			if (kind < 80) begin
				for (int i = 0; i < 17; i++)
					line_q.push_back((i == 2 || i == 5 || i == 10 || i == 13 || i == 16) ?
						CH_COLON : 8'(CH_ZERO + $urandom_range(9)));
				// overwrite one position of a well-formed stamp with a near-miss character
				if (kind >= 55) begin
					pos = $urandom_range(16);
					line_q[pos] = near_miss();
				end
				// trailing text, long enough at times to fill the store
				repeat ($urandom_range(3) == 0 ? $urandom_range(8, 20) : $urandom_range(0, 3))
					line_q.push_back($urandom_range(7) == 0 ? 8'h00 : text_byte());
			end else if (kind < 92) begin
				repeat ($urandom_range(16))
					line_q.push_back(text_byte());
			end else begin
				repeat ($urandom_range(30, 45))
					line_q.push_back(text_byte());
			end
			line_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
			foreach (line_q[i]) begin
				push_byte(line_q[i], 1'b0, NO_STAMP);
				sender_gap();
			end
			if (line_cnt % 20 == 0)
				drain_results();
		end

		drain_results();
		repeat (25) @(posedge clk);
		$display("covered %0d request bytes and %0d lines: %0d valid stamps, %0d rejected",
			sent_cnt, line_cnt, good_cnt, bad_cnt);
		$display("idle mixes 0/71/23 percent, full store, zero bytes, near-miss characters");
		if (err_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: timestamp_line_parser.f
rtl/tlp_pkg.sv
rtl/tlp_ram.sv
rtl/tlp_scan.sv
rtl/timestamp_line_parser.sv
rtl/tlp_chk.sv
dv/tb_timestamp_line_parser.sv
